/* hw/rtl/crc16lsb_pkg.sv */
// Package for the CRC-16 (poly 0x8005, LSB-first input) byte stream block.
// Holds the shared constants, the queue entry type and the byte fold function.
// No dependencies.
`timescale 1ns / 1ps

package crc16lsb_pkg;

  localparam int unsigned CrcWidth          = 16;
  localparam int unsigned ByteWidth         = 8;
  localparam logic [CrcWidth-1:0] CrcPoly   = 16'h8005;
  localparam logic [CrcWidth-1:0] CrcInit   = 16'h0000;
  localparam int unsigned QueueDepthDefault = 2;

  // One finished CRC traveling from the front to the back.
  typedef struct packed {
    logic                valid;
    logic [CrcWidth-1:0] crc;
  } crc_entry_t;

  // Folds one byte into the CRC, bit 0 first, register shifting toward its MSB.
  function automatic logic [CrcWidth-1:0] fold_byte(input logic [CrcWidth-1:0] crc_in,
                                                     input logic [ByteWidth-1:0] data);
    logic [CrcWidth-1:0] reg_v;
    logic                fb;
    reg_v = crc_in;
    for (int k = 0; k < ByteWidth; k++) begin
      fb    = data[k] ^ reg_v[CrcWidth-1];
      reg_v = {reg_v[CrcWidth-2:0], 1'b0};
      if (fb) begin
        reg_v = reg_v ^ CrcPoly;
      end
    end
    return reg_v;
  endfunction

endpackage

/* hw/rtl/crc16lsb_front.sv */
// Front part: accepts message bytes and keeps the running CRC register.
// Depends on crc16lsb_pkg for the fold function and the queue entry type.
`timescale 1ns / 1ps

module crc16lsb_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  logic                                    full_i,
  input  logic [crc16lsb_pkg::ByteWidth-1:0]      data_byte_i,
  input  logic                                    end_of_message_i,
  output crc16lsb_pkg::crc_entry_t                enq_o
);

  logic [crc16lsb_pkg::CrcWidth-1:0] crc_q, crc_d;
  logic [crc16lsb_pkg::CrcWidth-1:0] folded;
  logic                              accept;

  assign accept = push_i & ~full_i;
  assign folded = crc16lsb_pkg::fold_byte(crc_q, data_byte_i);

  // The last byte of a message hands its CRC to the queue and restarts the register.
  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = end_of_message_i ? crc16lsb_pkg::CrcInit : folded;
    end
  end

  assign enq_o.valid = accept & end_of_message_i;
  assign enq_o.crc   = folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= crc16lsb_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

/* hw/rtl/crc16lsb_fifo.sv */
// Short queue of finished CRC words between the front and the back.
// Depends on crc16lsb_pkg for the entry type and widths.
`timescale 1ns / 1ps

module crc16lsb_fifo #(
  parameter int unsigned Depth = crc16lsb_pkg::QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  crc16lsb_pkg::crc_entry_t wr_i,
  output logic                     full_o,
  output crc16lsb_pkg::crc_entry_t head_o,
  input  logic                     rd_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [crc16lsb_pkg::CrcWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en, rd_en, not_empty;

  assign full_o    = (count_q == CntW'(Depth));
  assign not_empty = (count_q != '0);
  assign wr_en     = wr_i.valid & ~full_o;
  assign rd_en     = rd_i & not_empty;

  assign head_o.valid = not_empty;
  assign head_o.crc   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_i.crc;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a write");

endmodule

/* hw/rtl/crc16lsb_back.sv */
// Back part: takes one CRC word from the queue and hands it out as two items,
// low byte then high byte. Depends on crc16lsb_pkg for the entry type.
`timescale 1ns / 1ps

module crc16lsb_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  crc16lsb_pkg::crc_entry_t           head_i,
  output logic                               deq_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [crc16lsb_pkg::ByteWidth-1:0] crc_byte_o,
  output logic                               final_byte_o
);

  logic [crc16lsb_pkg::CrcWidth-1:0] word_q, word_d;
  logic                              valid_q, valid_d;
  logic                              phase_q, phase_d;
  logic                              taken, load;

  assign taken = pop_i & valid_q;
  assign load  = head_i.valid & (~valid_q | (taken & phase_q));
  assign deq_o = load;

  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      word_d  = head_i.crc;
      valid_d = 1'b1;
      phase_d = 1'b0;
    end else if (taken) begin
      if (phase_q) begin
        valid_d = 1'b0;
        phase_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
  end

  assign empty_o      = ~valid_q;
  assign crc_byte_o   = phase_q ? word_q[crc16lsb_pkg::CrcWidth-1:crc16lsb_pkg::ByteWidth]
                                : word_q[crc16lsb_pkg::ByteWidth-1:0];
  assign final_byte_o = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  a_high_follows_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && !phase_q) |=> (valid_q && phase_q && $stable(word_q)))
    else $error("high CRC byte did not follow the low byte");

  a_no_load_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !phase_q) |-> !load)
    else $error("new CRC word loaded before the high byte went out");

endmodule

/* hw/rtl/crc16_lsb_first_byte_stream.sv */
// Top level of the CRC-16 (poly 0x8005, LSB-first input) byte stream block.
// Instantiates crc16lsb_front, crc16lsb_fifo and crc16lsb_back; uses crc16lsb_pkg.
`timescale 1ns / 1ps

// How to use this block:
// Message bytes enter through a queue-style port. A byte is taken at a rising
// clock edge where push is high and full is low. Its bits are folded into a
// 16-bit CRC register (poly 0x8005, zero start, bit 0 first, no final XOR) by
// one XOR network, so a byte can be taken in every cycle while full is low.
// The byte flagged with end_of_message_i is folded in as well, and the finished
// CRC moves into a small queue while the register restarts at zero; the next
// message may begin in the very next cycle.
// Results leave through a second queue-style port. While empty is low the
// oldest item is on crc_byte_o/final_byte_o and is taken where pop is high.
// Each message yields two items: the low CRC byte with final_byte_o low, then
// the high CRC byte with final_byte_o high.
// The low byte becomes visible once the finished CRC has passed the queue and been
// loaded into the back part's output register; the high byte follows the edge that
// pops the low byte. Throughput: one byte per cycle on input while full is low; one
// item per cycle on output while pop is high, set by the single output register.
// If the receiver stalls, finished CRCs collect in the queue (QueueDepth words
// plus one in the output register); once the queue is full, full goes high
// and input bytes wait.
// Reset (rst_ni low, asynchronous) empties the CRC register, queue and output stage.

module crc16_lsb_first_byte_stream #(
  parameter int unsigned QueueDepth = crc16lsb_pkg::QueueDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [crc16lsb_pkg::ByteWidth-1:0] data_byte_i,
  input  logic                               end_of_message_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [crc16lsb_pkg::ByteWidth-1:0] crc_byte_o,
  output logic                               final_byte_o
);

  crc16lsb_pkg::crc_entry_t enq, head;
  logic                     deq;

  // Front: running CRC; emits a finished word on the last byte of a message.
  crc16lsb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .enq_o            (enq)
  );

  // Queue of finished CRC words; its full flag is the input port's full.
  crc16lsb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (enq),
    .full_o (full),
    .head_o (head),
    .rd_i   (deq)
  );

  // Back: splits each word into the low and high result items.
  crc16lsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .deq_o        (deq),
    .empty_o      (empty),
    .pop_i        (pop),
    .crc_byte_o   (crc_byte_o),
    .final_byte_o (final_byte_o)
  );

endmodule
